### hw/rtl/pbs_pkg.sv
// Package for the priority beep sequencer: commands, marks, state type and tone ROM.
package pbs_pkg;

	// Command codes carried by an input beat
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;

	// Sequence marks stored in the ROM
	localparam logic [7:0] MARK_REPEAT = 8'hFE;
	localparam logic [7:0] MARK_STOP   = 8'hFF;

	// Tick period in microseconds (documentation of the time base)
	localparam int TICK_US = 10000;

	localparam int NUM_SOUNDS_DEF = 12;
	localparam int ROM_SOUNDS     = 12;
	localparam int ROM_LEN        = 20;

	// Player state
	typedef struct packed {
		logic [3:0] sound;
		logic [4:0] pos;
		logic [7:0] ticks;
		logic       pin;
	} pbs_state_t;

	// Durations in ticks; rows are padded with stop marks
	localparam logic [7:0] TONE_ROM [ROM_SOUNDS][ROM_LEN] = '{
		// three beeps
		'{8'd20, 8'd10, 8'd20, 8'd10, 8'd20, 8'd10, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
		// SOS
		'{8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd40, 8'd40, 8'd10, 8'd40, 8'd10,
		  8'd40, 8'd40, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd70, 8'hFF, 8'hFF},
		// link lost
		'{8'd50, 8'd50, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
		// disarming
		'{8'd15, 8'd5, 8'd15, 8'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
		// arming
		'{8'd30, 8'd5, 8'd5, 8'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
		// battery critical
		'{8'd50, 8'd2, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
		// battery low
		'{8'd25, 8'd50, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
		// disarm held
		'{8'd0, 8'd100, 8'd10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
		// armed reminder
		'{8'd0, 8'd245, 8'd10, 8'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
		// short
		'{8'd10, 8'd10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
		// two short
		'{8'd5, 8'd5, 8'd5, 8'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
		// two long
		'{8'd20, 8'd15, 8'd35, 8'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}
	};

	// ROM lookup; no sound, unknown sounds and positions past the row read as stop
	function automatic logic [7:0] rom_read(input logic [3:0] sound, input logic [4:0] pos);
		logic [3:0] row;
		row = sound - 4'd1;
		if (sound == 4'd0 || sound > 4'(ROM_SOUNDS) || pos >= 5'(ROM_LEN)) begin
			return MARK_STOP;
		end
		return TONE_ROM[row][pos];
	endfunction

endpackage

### hw/rtl/pbs_if.sv
// Valid/ready channel interfaces for command beats and result beats.
interface pbs_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [3:0] sound_mode;

	modport source (output valid, output cmd, output sound_mode, input ready);
	modport sink (input valid, input cmd, input sound_mode, output ready);
endinterface

interface pbs_rsp_if;
	logic       valid;
	logic       ready;
	logic       pin_level;
	logic       playing;
	logic [3:0] active_sound;

	modport source (output valid, output pin_level, output playing, output active_sound,
		input ready);
	modport sink (input valid, input pin_level, input playing, input active_sound,
		output ready);
endinterface

### hw/rtl/pbs_step.sv
// Next-state logic: command decode, tick countdown and ROM entry stepping.
module pbs_step
	import pbs_pkg::*;
#(
	parameter int NUM_SOUNDS = NUM_SOUNDS_DEF
) (
	input  pbs_state_t cur,
	input  logic [1:0] cmd,
	input  logic [3:0] sound_mode,
	output pbs_state_t nxt
);

	logic       do_step;
	logic       do_silence;
	logic [3:0] step_sound;
	logic [4:0] step_pos;
	logic [7:0] val_pos;
	logic [7:0] val_first;
	logic [7:0] val;
	logic [4:0] pos_eff;
	logic       step_stop;

	// Command decode
	always_comb begin
		do_step    = 1'b0;
		do_silence = 1'b0;
		step_sound = cur.sound;
		step_pos   = cur.pos;
		case (cmd)
			CMD_TICK: begin
				if (cur.sound != 4'd0 && cur.ticks <= 8'd1) begin
					do_step = 1'b1;
				end
			end
			CMD_START: begin
				if (sound_mode == 4'd0) begin
					do_silence = 1'b1;
				end else if ({1'b0, sound_mode} <= 5'(NUM_SOUNDS) &&
					(cur.sound == 4'd0 || sound_mode < cur.sound)) begin
					do_step    = 1'b1;
					step_sound = sound_mode;
					step_pos   = 5'd0;
				end
			end
			CMD_STOP: begin
				if (sound_mode == 4'd0 || (cur.sound != 4'd0 && sound_mode == cur.sound)) begin
					do_silence = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// ROM reads: the addressed entry and the row head for a repeat
	assign val_pos   = rom_read(step_sound, step_pos);
	assign val_first = rom_read(step_sound, 5'd0);

	// Repeat handling: wrap to the row head, a repeat at the head silences
	always_comb begin
		val       = val_pos;
		pos_eff   = step_pos;
		step_stop = 1'b0;
		if (val_pos == MARK_REPEAT) begin
			if (step_pos == 5'd0 || val_first == MARK_REPEAT) begin
				step_stop = 1'b1;
			end else begin
				val     = val_first;
				pos_eff = 5'd0;
			end
		end
		if (val == MARK_STOP) begin
			step_stop = 1'b1;
		end
	end

	// State update
	always_comb begin
		nxt = cur;
		if (do_silence || (do_step && step_stop)) begin
			nxt = '0;
		end else if (do_step) begin
			nxt.sound = step_sound;
			nxt.pin   = pos_eff[0];
			nxt.ticks = val;
			nxt.pos   = pos_eff + 5'd1;
		end else if (cmd == CMD_TICK && cur.sound != 4'd0) begin
			nxt.ticks = cur.ticks - 8'd1;
		end
	end

endmodule

### hw/rtl/priority_beep_sequencer.sv
// Top level of the priority beep sequencer: player state and result register.
// Latency: a result beat is valid in the cycle after its command beat is taken.
// Throughput: one command beat per cycle while held results are taken; ROM lookup and
// step finish in that cycle. A new result enters as the held one is taken, no bubble.
// Reset: asynchronous, silent state (no sound, pin low), no result pending.
module priority_beep_sequencer
	import pbs_pkg::*;
#(
	parameter int NUM_SOUNDS = NUM_SOUNDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	pbs_req_if.sink      req,
	pbs_rsp_if.source    rsp
);

	pbs_state_t state_q;
	pbs_state_t state_nxt;
	logic       rsp_valid_q;
	logic       pin_q;
	logic       playing_q;
	logic [3:0] sound_q;
	logic       accept;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	pbs_step #(
		.NUM_SOUNDS(NUM_SOUNDS)
	) u_step (
		.cur       (state_q),
		.cmd       (req.cmd),
		.sound_mode(req.sound_mode),
		.nxt       (state_nxt)
	);

	// Player state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// Result beat control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pin_q     <= state_nxt.pin;
			playing_q <= state_nxt.sound != 4'd0;
			sound_q   <= state_nxt.sound;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.pin_level    = pin_q;
	assign rsp.playing      = playing_q;
	assign rsp.active_sound = sound_q;

endmodule

### tb/sv/pbs_checker.sv
`timescale 1ns / 1ps
// Checker for the priority beep sequencer: tone player model and result beat comparison.
module pbs_checker
	import pbs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	pbs_req_if   req,
	pbs_rsp_if   rsp,
	output int   fail_total,
	output int   pending,
	output int   tick_beats,
	output int   start_beats,
	output int   stop_beats,
	output int   unused_beats,
	output int   results_checked
);

	localparam int TONE_ROWS = 12;
	localparam int TONE_LEN  = 20;

	typedef struct packed {
		logic [3:0] snd;
		logic [4:0] pos;
		logic [7:0] ticks;
		logic       pin;
	} player_t;

	typedef struct packed {
		logic       pin_level;
		logic       playing;
		logic [3:0] active_sound;
	} tone_result_t;

	localparam player_t SILENT = '0;

	player_t      player = SILENT;
	tone_result_t tone_q[$];
	int           errors = 0;
	int           n_tick = 0;
	int           n_start = 0;
	int           n_stop = 0;
	int           n_unused = 0;
	int           n_checked = 0;

	assign fail_total      = errors;
	assign pending         = tone_q.size();
	assign tick_beats      = n_tick;
	assign start_beats     = n_start;
	assign stop_beats      = n_stop;
	assign unused_beats    = n_unused;
	assign results_checked = n_checked;

	// Duration table, one row per sound, index 0 leftmost; unused slots hold stop marks
	function automatic logic [7:0] tone_entry(input logic [3:0] snd, input logic [4:0] idx);
		logic [0:TONE_LEN-1][7:0] row;
		row = {TONE_LEN{MARK_STOP}};
		if (snd == 4'd0 || snd > 4'(TONE_ROWS) || idx >= 5'(TONE_LEN)) begin
			return MARK_STOP;
		end
		case (snd)
			4'd1: begin
				row = {8'd20, 8'd10, 8'd20, 8'd10, 8'd20, 8'd10, {14{MARK_STOP}}};
			end
			4'd2: begin
				row = {8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd40, 8'd40, 8'd10, 8'd40,
					8'd10, 8'd40, 8'd40, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd70,
					{2{MARK_STOP}}};
			end
			4'd3: begin
				row = {8'd50, 8'd50, {18{MARK_STOP}}};
			end
			4'd4: begin
				row = {8'd15, 8'd5, 8'd15, 8'd5, {16{MARK_STOP}}};
			end
			4'd5: begin
				row = {8'd30, 8'd5, 8'd5, 8'd5, {16{MARK_STOP}}};
			end
			4'd6: begin
				row = {8'd50, 8'd2, {18{MARK_STOP}}};
			end
			4'd7: begin
				row = {8'd25, 8'd50, {18{MARK_STOP}}};
			end
			4'd8: begin
				row = {8'd0, 8'd100, 8'd10, {17{MARK_STOP}}};
			end
			4'd9: begin
				row = {8'd0, 8'd245, 8'd10, 8'd5, {16{MARK_STOP}}};
			end
			4'd10: begin
				row = {8'd10, 8'd10, {18{MARK_STOP}}};
			end
			4'd11: begin
				row = {8'd5, 8'd5, 8'd5, 8'd5, {16{MARK_STOP}}};
			end
			4'd12: begin
				row = {8'd20, 8'd15, 8'd35, 8'd5, {16{MARK_STOP}}};
			end
			default: begin
				row = {TONE_LEN{MARK_STOP}};
			end
		endcase
		return row[idx];
	endfunction

	// Load the entry at the current position; marks end or restart the pattern
	function automatic player_t next_entry(input player_t st);
		logic [7:0] dur;
		dur = tone_entry(st.snd, st.pos);
		if (dur == MARK_REPEAT) begin
			// a restart mark right at the head would loop forever, so it silences
			if (st.pos == 5'd0) begin
				return SILENT;
			end
			st.pos = 5'd0;
			dur = tone_entry(st.snd, 5'd0);
			if (dur == MARK_REPEAT) begin
				return SILENT;
			end
		end
		if (dur == MARK_STOP) begin
			return SILENT;
		end
		st.pin   = st.pos[0];
		st.ticks = dur;
		st.pos   = st.pos + 5'd1;
		return st;
	endfunction

	// Player state after one command beat
	function automatic player_t play_beat(input player_t st, input logic [1:0] c,
		input logic [3:0] m);
		case (c)
			CMD_TICK: begin
				// zero or one tick left: entry expires on this tick
				if (st.snd != 4'd0) begin
					if (st.ticks <= 8'd1) begin
						st = next_entry(st);
					end else begin
						st.ticks = st.ticks - 8'd1;
					end
				end
			end
			CMD_START: begin
				if (m == 4'd0) begin
					st = SILENT;
				end else if ({1'b0, m} <= 5'(NUM_SOUNDS_DEF) &&
					(st.snd == 4'd0 || m < st.snd)) begin
					st.snd = m;
					st.pos = 5'd0;
					st = next_entry(st);
				end
			end
			CMD_STOP: begin
				if (m == 4'd0 || (st.snd != 4'd0 && m == st.snd)) begin
					st = SILENT;
				end
			end
			default: begin
			end
		endcase
		return st;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	// Compare result beats first: a result at this edge belongs to an older command beat
	always @(posedge clk or negedge arst_n) begin
		tone_result_t want;
		if (!arst_n) begin
			player = SILENT;
			tone_q.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (tone_q.size() == 0) begin
					report_mismatch("result beat with nothing pending, sound",
						int'(rsp.active_sound), 0);
				end else begin
					want = tone_q.pop_front();
					n_checked++;
					if (rsp.pin_level !== want.pin_level) begin
						report_mismatch("pin_level", int'(rsp.pin_level),
							int'(want.pin_level));
					end
					if (rsp.playing !== want.playing) begin
						report_mismatch("playing", int'(rsp.playing), int'(want.playing));
					end
					if (rsp.active_sound !== want.active_sound) begin
						report_mismatch("active_sound", int'(rsp.active_sound),
							int'(want.active_sound));
					end
				end
			end
			if (req.valid && req.ready) begin
				player = play_beat(player, req.cmd, req.sound_mode);
				want.pin_level    = player.pin;
				want.playing      = (player.snd != 4'd0);
				want.active_sound = player.snd;
				tone_q.push_back(want);
				case (req.cmd)
					CMD_TICK:  n_tick++;
					CMD_START: n_start++;
					CMD_STOP:  n_stop++;
					default:   n_unused++;
				endcase
			end
		end
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the priority beep sequencer: clock, reset, command stimulus and verdict.
module tb_top;
	import pbs_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 10;
	localparam int PLAY_QUOTA   = 650;
	localparam int GAP_MAX      = 18;
	localparam int DRAIN_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 300000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_total;
	int   pending;
	int   tick_beats;
	int   start_beats;
	int   stop_beats;
	int   unused_beats;
	int   results_checked;
	int   cycles = 0;
	bit   tx_calm = 1'b0;
	bit   rx_calm = 1'b0;

	pbs_req_if req ();
	pbs_rsp_if rsp ();

	priority_beep_sequencer #(
		.NUM_SOUNDS(NUM_SOUNDS_DEF)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	pbs_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.rsp             (rsp),
		.fail_total      (fail_total),
		.pending         (pending),
		.tick_beats      (tick_beats),
		.start_beats     (start_beats),
		.stop_beats      (stop_beats),
		.unused_beats    (unused_beats),
		.results_checked (results_checked)
	);

	// Clock
	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycles, pending);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Idle cycles before a beat; now and then switch between busy and calm stretches
	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 39) == 0) begin
			calm = !calm;
		end
		return calm ? 0 : $urandom_range(0, GAP_MAX);
	endfunction

	// Present one command beat at a falling edge, hold it until taken
	task automatic send_beat(input logic [1:0] c, input logic [3:0] m);
		int gap;
		gap = draw_gap(tx_calm);
		@(negedge clk);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid      <= 1'b1;
		req.cmd        <= c;
		req.sound_mode <= m;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
	endtask

	// Result side: stall a random number of cycles before each beat
	initial begin
		int gap;
		rsp.ready = 1'b0;
		forever begin
			gap = draw_gap(rx_calm);
			@(negedge clk);
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!rsp.valid);
		end
	end

	// Command stimulus
	initial begin
		logic [3:0] quick_sounds [6];
		logic [3:0] snd;
		int         played;
		int         run_len;
		int         pick;
		quick_sounds = '{4'd1, 4'd4, 4'd5, 4'd6, 4'd10, 4'd11};
		played = 0;
		req.valid      = 1'b0;
		req.cmd        = CMD_TICK;
		req.sound_mode = 4'd0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: idle cases, priorities, zero-length entry, stops
		send_beat(CMD_TICK, 4'd0);
		send_beat(CMD_STOP, 4'd0);
		send_beat(CMD_UNUSED, 4'd15);
		send_beat(CMD_START, 4'd13);
		send_beat(CMD_START, 4'd15);
		send_beat(CMD_START, 4'd12);
		send_beat(CMD_START, 4'd12);
		send_beat(CMD_START, 4'd8);
		send_beat(CMD_TICK, 4'd0);
		send_beat(CMD_TICK, 4'd15);
		send_beat(CMD_STOP, 4'd3);
		send_beat(CMD_START, 4'd9);
		send_beat(CMD_STOP, 4'd8);
		send_beat(CMD_START, 4'd9);
		send_beat(CMD_TICK, 4'd0);
		send_beat(CMD_START, 4'd1);
		send_beat(CMD_START, 4'd2);
		send_beat(CMD_START, 4'd0);
		send_beat(CMD_START, 4'd10);
		send_beat(CMD_UNUSED, 4'd10);
		send_beat(CMD_TICK, 4'd0);
		send_beat(CMD_STOP, 4'd0);
		send_beat(CMD_START, 4'd7);
		send_beat(CMD_STOP, 4'd7);

		// random: mostly a start followed by a run of ticks, with some noise between
		while (played < PLAY_QUOTA) begin
			if ($urandom_range(0, 99) < 75) begin
				if ($urandom_range(0, 9) < 7) begin
					snd = quick_sounds[$urandom_range(0, 5)];
				end else begin
					snd = 4'($urandom_range(1, NUM_SOUNDS_DEF));
				end
				send_beat(CMD_START, snd);
				run_len = $urandom_range(1, 60);
				repeat (run_len) begin
					pick = $urandom_range(0, 99);
					if (pick < 4) begin
						send_beat(CMD_START, 4'($urandom_range(1, NUM_SOUNDS_DEF)));
					end else if (pick < 6) begin
						send_beat(CMD_STOP, snd);
					end else if (pick < 7) begin
						send_beat(CMD_STOP, 4'($urandom));
					end else begin
						send_beat(CMD_TICK, 4'($urandom));
					end
				end
				played += run_len + 1;
			end else begin
				repeat ($urandom_range(1, 4)) begin
					send_beat(2'($urandom), 4'($urandom));
				end
			end
		end

		@(negedge clk);
		req.valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("commands seen: %0d ticks, %0d starts, %0d stops, %0d unused codes",
			tick_beats, start_beats, stop_beats, unused_beats);
		$display("result beats compared: %0d, mismatches: %0d", results_checked, fail_total);
		if (fail_total == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
